[src/fraction_sum_reducer_top_assert.svh]
// assertion macros for the fraction sum reducer
// expects clk and arst_n in the scope where a macro is used
`ifndef FRACTION_SUM_REDUCER_TOP_ASSERT_SVH
`define FRACTION_SUM_REDUCER_TOP_ASSERT_SVH

// condition in one cycle implies result in the same cycle
`define FSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fraction_sum_reducer: same-cycle check failed");

// condition in one cycle implies result in the next cycle
`define FSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fraction_sum_reducer: next-cycle check failed");

`endif

[src/fsr_pkg.sv]
// shared constants for the fraction sum reducer
// no dependencies
package fsr_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_BITS    = 32;
	localparam int MUL_DIG       = 32;
	localparam int QUEUE_DEPTH   = 2;
endpackage

[src/fsr_front.sv]
// front end: accepts input transfers, widens the fields, queues them
// depends on fsr_pkg
module fsr_front import fsr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic signed [FIELD_BITS-1:0] s_num,
	input  logic signed [FIELD_BITS-1:0] s_den,
	input  logic                         s_last,
	output logic                         q_valid,
	output logic [WORD_BITS-1:0]         q_num,
	output logic [WORD_BITS-1:0]         q_den,
	output logic                         q_last,
	input  logic                         q_pop
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WORD_BITS-1:0] num_q [QUEUE_DEPTH];
	logic [WORD_BITS-1:0] den_q [QUEUE_DEPTH];
	logic                 last_q [QUEUE_DEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 push;

	assign s_tready = (count_q != CW'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_num    = num_q[rd_ptr_q];
	assign q_den    = den_q[rd_ptr_q];
	assign q_last   = last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			num_q[wr_ptr_q]  <= WORD_BITS'(s_num);
			den_q[wr_ptr_q]  <= WORD_BITS'(s_den);
			last_q[wr_ptr_q] <= s_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

[src/fsr_accum.sv]
// back end: cross-multiply accumulate of queued fractions
// depends on fsr_pkg
module fsr_accum import fsr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [WORD_BITS-1:0] q_num,
	input  logic [WORD_BITS-1:0] q_den,
	input  logic                 q_last,
	output logic                 q_pop,
	output logic                 hand_valid,
	output logic [WORD_BITS-1:0] hand_num,
	output logic [WORD_BITS-1:0] hand_den,
	input  logic                 hand_ready
);
	localparam int NDIG  = (WORD_BITS + MUL_DIG - 1) / MUL_DIG;
	localparam int PAD   = NDIG * MUL_DIG;
	localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int PPW   = 2 * MUL_DIG;

	typedef enum logic {AC_MUL, AC_DRAIN} ac_state_t;

	ac_state_t            state_q;
	logic [IDX_W-1:0]     i_q, j_q, sh_s1;
	logic [WORD_BITS-1:0] acc_num_q, acc_den_q, nsum_q, dsum_q;
	logic [PPW-1:0]       pp0_s1, pp1_s1, pp2_s1;
	logic                 ppv_s1;

	logic [PAD-1:0]       an_pad, ad_pad, n_pad, d_pad;
	logic [MUL_DIG-1:0]   an_dig, ad_dig, n_dig, d_dig;
	logic [WORD_BITS-1:0] tot_n, tot_d;
	logic                 last_step, row_end, done_ok;

	function automatic logic [WORD_BITS-1:0] place(input logic [PPW-1:0] p,
	                                               input logic [IDX_W-1:0] s);
		logic [PAD+PPW-1:0] e;
		e = (PAD + PPW)'(p) << (s * MUL_DIG);
		return e[WORD_BITS-1:0];
	endfunction

	assign an_pad = PAD'(acc_num_q);
	assign ad_pad = PAD'(acc_den_q);
	assign n_pad  = PAD'(q_num);
	assign d_pad  = PAD'(q_den);
	assign an_dig = an_pad[i_q*MUL_DIG +: MUL_DIG];
	assign ad_dig = ad_pad[i_q*MUL_DIG +: MUL_DIG];
	assign n_dig  = n_pad[j_q*MUL_DIG +: MUL_DIG];
	assign d_dig  = d_pad[j_q*MUL_DIG +: MUL_DIG];

	assign last_step = (i_q == IDX_W'(NDIG - 1));
	assign row_end   = (({1'b0, i_q} + {1'b0, j_q}) == (IDX_W + 1)'(NDIG - 1));

	assign tot_n = nsum_q + place(pp0_s1, sh_s1) + place(pp1_s1, sh_s1);
	assign tot_d = dsum_q + place(pp2_s1, sh_s1);

	assign done_ok    = (state_q == AC_DRAIN) && (!q_last || hand_ready);
	assign q_pop      = done_ok;
	assign hand_valid = (state_q == AC_DRAIN) && q_last;
	assign hand_num   = tot_n;
	assign hand_den   = tot_d;

	always_ff @(posedge clk) begin
		if (state_q == AC_MUL && q_valid) begin
			pp0_s1 <= an_dig * d_dig;
			pp1_s1 <= ad_dig * n_dig;
			pp2_s1 <= ad_dig * d_dig;
			sh_s1  <= i_q + j_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= AC_MUL;
			i_q       <= '0;
			j_q       <= '0;
			acc_num_q <= '0;
			acc_den_q <= WORD_BITS'(1);
			nsum_q    <= '0;
			dsum_q    <= '0;
			ppv_s1    <= 1'b0;
		end else begin
			case (state_q)
				AC_MUL: begin
					if (q_valid) begin
						ppv_s1 <= 1'b1;
						if (ppv_s1) begin
							nsum_q <= tot_n;
							dsum_q <= tot_d;
						end
						if (last_step) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= AC_DRAIN;
						end else if (row_end) begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				AC_DRAIN: begin
					if (done_ok) begin
						acc_num_q <= q_last ? '0 : tot_n;
						acc_den_q <= q_last ? WORD_BITS'(1) : tot_d;
						nsum_q    <= '0;
						dsum_q    <= '0;
						ppv_s1    <= 1'b0;
						state_q   <= AC_MUL;
					end
				end
				default: begin
					state_q <= AC_MUL;
				end
			endcase
		end
	end
endmodule

[src/fsr_divider.sv]
// radix-2 restoring divider, truncating signed quotient and remainder
// depends on fsr_pkg
module fsr_divider import fsr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 done,
	output logic [WORD_BITS-1:0] quot,
	output logic [WORD_BITS-1:0] rem
);
	localparam int CW = $clog2(WORD_BITS + 1);

	logic                 busy_q, done_q, nega_q, negq_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] q_q, r_q, mb_q;
	logic [WORD_BITS-1:0] ma, mb;
	logic [WORD_BITS:0]   r_sh, r_sub;
	logic                 fits;

	assign ma    = dividend[WORD_BITS-1] ? WORD_BITS'(0) - dividend : dividend;
	assign mb    = divisor[WORD_BITS-1] ? WORD_BITS'(0) - divisor : divisor;
	assign r_sh  = {r_q, q_q[WORD_BITS-1]};
	assign fits  = (r_sh >= {1'b0, mb_q});
	assign r_sub = r_sh - {1'b0, mb_q};

	assign done = done_q;
	assign quot = negq_q ? WORD_BITS'(0) - q_q : q_q;
	assign rem  = nega_q ? WORD_BITS'(0) - r_q : r_q;

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= ma;
			r_q    <= '0;
			mb_q   <= mb;
			nega_q <= dividend[WORD_BITS-1];
			negq_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
		end else if (busy_q) begin
			r_q <= fits ? r_sub[WORD_BITS-1:0] : r_sh[WORD_BITS-1:0];
			q_q <= {q_q[WORD_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

[src/fsr_reduce.sv]
// gcd reduction of a finished sum and the output register
// depends on fsr_pkg and fsr_divider
module fsr_reduce import fsr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hand_valid,
	input  logic [WORD_BITS-1:0]  hand_num,
	input  logic [WORD_BITS-1:0]  hand_den,
	output logic                  hand_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [FIELD_BITS-1:0] m_num,
	output logic [FIELD_BITS-1:0] m_den
);
	typedef enum logic [2:0] {RD_IDLE, RD_TEST, RD_REM, RD_QNUM, RD_QDEN, RD_OUT} rd_state_t;

	rd_state_t            state_q;
	logic [WORD_BITS-1:0] num_q, den_q, a_q, b_q, qn_q, res_num_q, res_den_q;
	logic [WORD_BITS-1:0] out_num_q, out_den_q;
	logic                 out_valid_q;
	logic                 out_load;

	logic                 div_start, div_done;
	logic [WORD_BITS-1:0] div_a, div_b, div_q, div_r;

	fsr_divider #(.WORD_BITS(WORD_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	always_comb begin
		div_start = 1'b0;
		div_a     = a_q;
		div_b     = b_q;
		case (state_q)
			RD_TEST: begin
				if (b_q != '0) begin
					div_start = 1'b1;
				end else if (a_q != '0) begin
					div_start = 1'b1;
					div_a     = num_q;
					div_b     = a_q;
				end
			end
			RD_QNUM: begin
				div_start = div_done;
				div_a     = den_q;
				div_b     = a_q;
			end
			default: begin
			end
		endcase
	end

	assign hand_ready = (state_q == RD_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_num      = FIELD_BITS'(out_num_q);
	assign m_den      = FIELD_BITS'(out_den_q);
	assign out_load   = (state_q == RD_OUT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RD_IDLE;
			out_valid_q <= 1'b0;
			num_q       <= '0;
			den_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			qn_q        <= '0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			out_num_q   <= '0;
			out_den_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				RD_IDLE: begin
					if (hand_valid) begin
						num_q   <= hand_num;
						den_q   <= hand_den;
						a_q     <= hand_num;
						b_q     <= hand_den;
						state_q <= RD_TEST;
					end
				end
				RD_TEST: begin
					if (b_q != '0) begin
						state_q <= RD_REM;
					end else if (a_q != '0) begin
						state_q <= RD_QNUM;
					end else begin
						res_num_q <= num_q;
						res_den_q <= den_q;
						state_q   <= RD_OUT;
					end
				end
				RD_REM: begin
					if (div_done) begin
						a_q     <= b_q;
						b_q     <= div_r;
						state_q <= RD_TEST;
					end
				end
				RD_QNUM: begin
					if (div_done) begin
						qn_q    <= div_q;
						state_q <= RD_QDEN;
					end
				end
				RD_QDEN: begin
					if (div_done) begin
						res_num_q <= qn_q;
						res_den_q <= div_q;
						state_q   <= RD_OUT;
					end
				end
				RD_OUT: begin
					if (out_load) begin
						out_num_q <= res_num_q;
						out_den_q <= res_den_q;
						state_q   <= RD_IDLE;
					end
				end
				default: begin
					state_q <= RD_IDLE;
				end
			endcase
		end
	end
endmodule

[src/fraction_sum_reducer_top.sv]
// Sums a stream of signed fractions by cross-multiplication, wrapping at WORD_BITS bits, and on
// the transfer marked tlast adds that fraction, divides the sum by its Euclid gcd (truncating
// remainder, sign of the last nonzero term) and sends the reduced fraction; a zero gcd sends the
// sum as it stands, and the sum restarts at 0/1. Input transfers go into a two-entry queue.
// Each item then takes P multiply steps and a drain step in the multiply-accumulate, with
// P = n(n+1)/2 and n = ceil(WORD_BITS/32): three 32x32 multipliers produce one digit pair of
// every product per cycle while an item is queued, and the drain step adds and commits. The
// reduction of a finished set runs in a shared radix-2 divider, with one division per Euclid
// step (at most about 1.44*WORD_BITS steps) and two for the final quotients. The next set
// accumulates meanwhile; its last item waits until the reducer is free. No clearing pass after
// reset. Depends on fsr_pkg, fsr_front, fsr_accum, fsr_divider, fsr_reduce and the assertion
// header.
module fraction_sum_reducer_top import fsr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [2*FIELD_BITS-1:0] s_axis_tdata,  // frac_num, frac_den
	input  logic                    s_axis_tlast,  // last_item
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [2*FIELD_BITS-1:0] m_axis_tdata   // sum_num, sum_den
);
	logic                 q_valid, q_last, q_pop;
	logic [WORD_BITS-1:0] q_num, q_den;
	logic                 hand_valid, hand_ready;
	logic [WORD_BITS-1:0] hand_num, hand_den;
	logic [FIELD_BITS-1:0] sum_num, sum_den;

	fsr_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_num    (s_axis_tdata[FIELD_BITS-1:0]),
		.s_den    (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
		.s_last   (s_axis_tlast),
		.q_valid  (q_valid),
		.q_num    (q_num),
		.q_den    (q_den),
		.q_last   (q_last),
		.q_pop    (q_pop)
	);

	fsr_accum #(.WORD_BITS(WORD_BITS)) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_num      (q_num),
		.q_den      (q_den),
		.q_last     (q_last),
		.q_pop      (q_pop),
		.hand_valid (hand_valid),
		.hand_num   (hand_num),
		.hand_den   (hand_den),
		.hand_ready (hand_ready)
	);

	fsr_reduce #(.WORD_BITS(WORD_BITS)) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand_valid (hand_valid),
		.hand_num   (hand_num),
		.hand_den   (hand_den),
		.hand_ready (hand_ready),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_num      (sum_num),
		.m_den      (sum_den)
	);

	assign m_axis_tdata = {sum_den, sum_num};

`include "fraction_sum_reducer_top_assert.svh"

	// a set handed to the reducer blocks the next one until it is done
	`FSR_ASSERT_NEXT(a_hand_busy, hand_valid && hand_ready, !hand_ready)
	// a transfer into an idle queue shows up at the back end next cycle
	`FSR_ASSERT_NEXT(a_queue_fill, s_axis_tvalid && s_axis_tready && !q_valid, q_valid)
	// the back end only retires an item that is there
	`FSR_ASSERT_NOW(a_pop_valid, q_pop, q_valid)
endmodule

[tb/sv/tb.sv]
// self-checking testbench for fraction_sum_reducer_top: fraction sets in, reduced sums out
// predicts each reduced sum in-line and compares it with the output stream
// depends on fsr_pkg and fraction_sum_reducer_top
module tb;
	import fsr_pkg::*;

	localparam int WB          = WORD_BITS_DEF;
	localparam int QUIET_LIMIT = 20000;
	localparam int TAIL_CYCLES = 2000;
	localparam int N_ITEMS     = 650;

	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_1  = 32'hffff_ffff;

	typedef enum int { PH_FREE, PH_TX_IDLE, PH_RX_STALL, PH_BOTH } idle_phase_t;

	typedef logic [WB-1:0] word_t;

	typedef struct {
		logic [31:0] num;
		logic [31:0] den;
		bit          last;
		idle_phase_t phase;
		bit          drain;
	} frac_item_t;

	typedef struct {
		logic [31:0] num;
		logic [31:0] den;
	} sum_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [2*FIELD_BITS-1:0] s_axis_tdata = '0;
	logic                    s_axis_tlast = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [2*FIELD_BITS-1:0] m_axis_tdata;

	frac_item_t pending[$];
	sum_t       sums_due[$];
	int         sets_sent = 0;
	int         sums_seen = 0;
	int         errors = 0;
	int         quiet = 0;
	int         item_idx = 0;
	int         rx_stall_pct = 0;
	word_t      acc_num = word_t'(0);
	word_t      acc_den = word_t'(1);

	fraction_sum_reducer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic word_t magnitude(word_t x);
		return x[WB-1] ? -x : x;
	endfunction

	function automatic word_t trunc_rem(word_t a, word_t b);
		word_t r;
		r = magnitude(a) % magnitude(b);
		return a[WB-1] ? -r : r;
	endfunction

	function automatic word_t trunc_quot(word_t a, word_t b);
		word_t q;
		q = magnitude(a) / magnitude(b);
		return (a[WB-1] != b[WB-1]) ? -q : q;
	endfunction

	function automatic idle_phase_t phase_of(int idx);
		return idle_phase_t'((idx / 80) % 4);
	endfunction

	task automatic add_item(logic [31:0] num, logic [31:0] den, bit last, bit drain,
			idle_phase_t phase);
		frac_item_t it;
		it.num   = num;
		it.den   = den;
		it.last  = last;
		it.drain = drain;
		it.phase = phase;
		pending.push_back(it);
		item_idx++;
	endtask

	function automatic logic [31:0] rand_word(bit nonzero_bias);
		logic [31:0] v;
		int          k;
		k = $urandom_range(99);
		if (k < 45) begin
			v = 32'($signed($urandom_range(40)) - 20);
			if (nonzero_bias && v == 32'd0)
				v = 32'd1;
		end else if (k < 55) begin
			case ($urandom_range(4))
				0: v = MOST_NEG;
				1: v = MOST_POS;
				2: v = MINUS_1;
				3: v = 32'd0;
				default: v = 32'd1;
			endcase
		end else if (k < 75) begin
			v = 32'($signed($urandom_range(2000)) - 1000);
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (pending[0].drain && (s_axis_tvalid || sets_sent != sums_seen)) begin
				s_axis_tvalid <= 1'b0;
			end else if ((pending[0].phase == PH_TX_IDLE && $urandom_range(99) < 64) ||
					(pending[0].phase == PH_BOTH && $urandom_range(99) < 32)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {pending[0].den, pending[0].num};
				s_axis_tlast  <= pending[0].last;
				case (pending[0].phase)
					PH_RX_STALL: rx_stall_pct <= 64;
					PH_BOTH:     rx_stall_pct <= 32;
					default:     rx_stall_pct <= 0;
				endcase
				pending.pop_front();
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// monitor and sum prediction
	always @(posedge clk) begin : monitor
		word_t n, d, a, b, t, rn, rd;
		sum_t  want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected transfer, actual num %h den %h", $time,
						m_axis_tdata[31:0], m_axis_tdata[63:32]);
					errors++;
				end else begin
					want = sums_due.pop_front();
					if (m_axis_tdata[31:0] !== want.num) begin
						$display("%0t: sum_num mismatch, expected %h actual %h", $time,
							want.num, m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tdata[63:32] !== want.den) begin
						$display("%0t: sum_den mismatch, expected %h actual %h", $time,
							want.den, m_axis_tdata[63:32]);
						errors++;
					end
				end
				sums_seen <= sums_seen + 1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n = word_t'($signed(s_axis_tdata[31:0]));
				d = word_t'($signed(s_axis_tdata[63:32]));
				acc_num = acc_num * d + acc_den * n;
				acc_den = acc_den * d;
				if (s_axis_tlast) begin
					a = acc_num;
					b = acc_den;
					while (b != '0) begin
						t = trunc_rem(a, b);
						a = b;
						b = t;
					end
					if (a != '0) begin
						rn = trunc_quot(acc_num, a);
						rd = trunc_quot(acc_den, a);
					end else begin
						rn = acc_num;
						rd = acc_den;
					end
					want.num = 32'(rn);
					want.den = 32'(rd);
					sums_due.push_back(want);
					acc_num = word_t'(0);
					acc_den = word_t'(1);
					sets_sent <= sets_sent + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin : stimulus
		int  len;
		int  k;
		bit  drain;
		// directed sets
		add_item(32'd6, 32'd4, 1'b1, 1'b0, PH_FREE);
		add_item(32'd1, 32'd2, 1'b0, 1'b0, PH_FREE);
		add_item(32'd1, 32'd3, 1'b0, 1'b0, PH_FREE);
		add_item(32'd1, 32'd6, 1'b1, 1'b0, PH_FREE);
		// negative gcd flips both signs
		add_item(-32'sd4, -32'sd6, 1'b1, 1'b0, PH_FREE);
		add_item(MOST_NEG, MINUS_1, 1'b1, 1'b0, PH_FREE);
		// zero gcd leaves the sum as it is, then sets with a zero or extreme field
		add_item(32'd0, 32'd0, 1'b1, 1'b0, PH_FREE);
		add_item(32'd5, 32'd0, 1'b1, 1'b0, PH_FREE);
		add_item(32'd0, 32'd7, 1'b1, 1'b0, PH_FREE);
		add_item(MOST_POS, MOST_POS, 1'b1, 1'b0, PH_FREE);
		add_item(MOST_NEG, MOST_NEG, 1'b1, 1'b0, PH_FREE);
		// wrapping products
		add_item(MINUS_1, MOST_POS, 1'b0, 1'b0, PH_FREE);
		add_item(MOST_NEG, MINUS_1, 1'b0, 1'b0, PH_FREE);
		add_item(32'd12345, -32'sd3, 1'b1, 1'b0, PH_FREE);
		add_item(32'd3, 32'd0, 1'b0, 1'b0, PH_FREE);
		add_item(32'd2, 32'd0, 1'b1, 1'b0, PH_FREE);
		add_item(MINUS_1, 32'd1, 1'b1, 1'b0, PH_FREE);
		add_item(32'd1, MINUS_1, 1'b1, 1'b0, PH_FREE);
		add_item(MOST_POS, MOST_NEG, 1'b1, 1'b0, PH_FREE);
		// random sets
		while (item_idx < N_ITEMS) begin
			k = $urandom_range(99);
			if (k < 70)
				len = $urandom_range(4, 1);
			else if (k < 95)
				len = $urandom_range(10, 5);
			else
				len = $urandom_range(30, 11);
			drain = (item_idx == 19) || ($urandom_range(19) == 0);
			for (int i = 0; i < len; i++) begin
				add_item(rand_word(1'b0), rand_word(1'b1), i == len - 1, drain && i == 0,
					phase_of(item_idx));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending.size() == 0 && !s_axis_tvalid);
		wait (sets_sent == sums_seen);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && sums_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
